### rtl/core/blec_pkg.sv
// ----------------------------------------------------------------------------
// blec_pkg
// Shared types and constants for the bounded list engine and its cells.
// ----------------------------------------------------------------------------
package blec_pkg;

   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int LEN_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 64;
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 16;
   localparam int STAT_W  = 2;
   // signed width that holds length + position without overflow
   localparam int K_W     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 2;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [FUNC_W-1:0]        func_type;
   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [STAT_W-1:0]        stat_type;

   localparam func_type FN_GET    = 3'd0;
   localparam func_type FN_SET    = 3'd1;
   localparam func_type FN_APPEND = 3'd2;
   localparam func_type FN_POP    = 3'd3;
   localparam func_type FN_INSERT = 3'd4;
   localparam func_type FN_REMOVE = 3'd5;

   localparam stat_type ST_OK      = 2'd0;
   localparam stat_type ST_RANGE   = 2'd1;
   localparam stat_type ST_FULL    = 2'd2;
   localparam stat_type ST_MISSING = 2'd3;

   typedef enum logic [2:0] {
      CO_HOLD,
      CO_WRITE,
      CO_INSERT,
      CO_DELETE_AT,
      CO_DELETE_REGION
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      idx_type     idx;
      len_type     count;
      elem_type    value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PREP,
      S_EXEC
   } state_type;

endpackage

### rtl/core/blec_if.sv
// ----------------------------------------------------------------------------
// blec_if
// Valid/ready channels for list operations and their results.
// ----------------------------------------------------------------------------
interface blec_req_if import blec_pkg::*; ();
   logic     valid;
   logic     ready;
   func_type func;
   pos_type  position;
   elem_type operand_value;

   modport source (output valid, output func, output position, output operand_value,
                   input ready);
   modport sink   (input valid, input func, input position, input operand_value,
                   output ready);
endinterface

interface blec_rsp_if import blec_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type read_value;
   len_type  list_length;
   stat_type status;

   modport source (output valid, output read_value, output list_length, output status,
                   input ready);
   modport sink   (input valid, input read_value, input list_length, input status,
                   output ready);
endinterface

### rtl/core/blec_cell.sv
// ----------------------------------------------------------------------------
// blec_cell
// One list entry: holds a value, takes a neighbor's value on a shift, and
// compares itself against the broadcast operand.
// ----------------------------------------------------------------------------
module blec_cell import blec_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  idx_type      cell_index,
   input  logic         in_region,
   input  elem_type     left_data,
   input  elem_type     right_data,
   output elem_type     data,
   output logic         match
);

   elem_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CO_HOLD: begin
            data_in = data_ff;
         end
         CO_WRITE: begin
            if (cell_index == cmd.idx) data_in = cmd.value;
         end
         CO_INSERT: begin
            if (cell_index > cmd.idx)       data_in = left_data;
            else if (cell_index == cmd.idx) data_in = cmd.value;
         end
         CO_DELETE_AT: begin
            if (cell_index >= cmd.idx) data_in = right_data;
         end
         CO_DELETE_REGION: begin
            if (in_region) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   // only entries inside the list take part in a search
   assign match = (LEN_W'(cell_index) < cmd.count) && (data_ff == cmd.value);

endmodule

### rtl/core/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_list_engine
// Ordered list of signed 64-bit values held in a chain of entry cells.
// ----------------------------------------------------------------------------
// Each item is accepted in S_IDLE; S_PREP resolves the position against the
// length and compares every cell with the operand; in S_EXEC the whole chain
// writes or shifts at once and the result is loaded. The result sits in an
// output register, so the next item is accepted while it waits; S_EXEC holds
// while that register is still full. Entries come up undefined after reset
// and no clearing pass is run: of the list state only the length register
// resets, and only entries below it are ever read.
module bounded_list_engine import blec_pkg::*; (
   input logic        clock,
   input logic        reset,
   blec_req_if.sink   req_bus,
   blec_rsp_if.source rsp_bus
);

   state_type state_ff, state_in;

   func_type  func_ff;
   pos_type   pos_ff;
   elem_type  val_ff;
   len_type   count_ff, count_in;
   idx_type   idx_ff;
   logic      range_ok_ff;
   logic [DEPTH-1:0] match_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   elem_type  rsp_value_ff;
   len_type   rsp_len_ff;
   stat_type  rsp_stat_ff;

   cell_cmd_type     cmd;
   elem_type         cell_data [DEPTH];
   logic [DEPTH-1:0] cell_match;
   logic [DEPTH-1:0] region;

   logic signed [K_W-1:0] len_s, pos_s, k_s, ins_s;
   logic      range_ok;
   idx_type   idx_sel;
   logic      accept, fire, full;
   elem_type  rd_value;
   stat_type  stat_val;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign full = (count_ff == LEN_W'(DEPTH));

   // position resolve
   always_comb begin
      len_s    = $signed(K_W'(count_ff));
      pos_s    = K_W'(pos_ff);
      k_s      = pos_s[K_W-1] ? (len_s + pos_s) : pos_s;
      range_ok = !k_s[K_W-1] && (k_s < len_s);
      ins_s    = k_s;
      if (k_s[K_W-1])     ins_s = '0;
      else if (k_s > len_s) ins_s = len_s;
      unique case (func_ff)
         FN_APPEND: idx_sel = count_ff[IDX_W-1:0];
         FN_INSERT: idx_sel = ins_s[IDX_W-1:0];
         default:   idx_sel = k_s[IDX_W-1:0];
      endcase
   end

   // cells at and above the first match
   assign region = match_ff | (~match_ff + DEPTH'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      cmd.op       = CO_HOLD;
      cmd.idx      = idx_ff;
      cmd.count    = count_ff;
      cmd.value    = val_ff;
      rd_value     = '0;
      stat_val     = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_PREP;
         end
         S_PREP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (func_ff)
               FN_GET: begin
                  if (range_ok_ff) rd_value = cell_data[idx_ff];
                  else             stat_val = ST_RANGE;
               end
               FN_SET: begin
                  if (range_ok_ff) cmd.op   = CO_WRITE;
                  else             stat_val = ST_RANGE;
               end
               FN_APPEND: begin
                  if (full) begin
                     stat_val = ST_FULL;
                  end else begin
                     cmd.op   = CO_WRITE;
                     count_in = count_ff + 1'b1;
                  end
               end
               FN_POP: begin
                  if (range_ok_ff) begin
                     rd_value = cell_data[idx_ff];
                     cmd.op   = CO_DELETE_AT;
                     count_in = count_ff - 1'b1;
                  end else begin
                     stat_val = ST_RANGE;
                  end
               end
               FN_INSERT: begin
                  if (full) begin
                     stat_val = ST_FULL;
                  end else begin
                     cmd.op   = CO_INSERT;
                     count_in = count_ff + 1'b1;
                  end
               end
               FN_REMOVE: begin
                  if (|match_ff) begin
                     cmd.op   = CO_DELETE_REGION;
                     count_in = count_ff - 1'b1;
                  end else begin
                     stat_val = ST_MISSING;
                  end
               end
               default: begin
                  stat_val = ST_OK;
               end
            endcase
            if (fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               cmd.op   = CO_HOLD;
               count_in = count_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         elem_type left_d, right_d;
         if (g == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_left
            assign left_d = cell_data[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_right
            assign right_d = cell_data[g+1];
         end
         blec_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_index (IDX_W'(g)),
            .in_region  (region[g]),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (cell_match[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_bus.func;
         pos_ff  <= req_bus.position;
         val_ff  <= req_bus.operand_value;
      end
      if (state_ff == S_PREP) begin
         idx_ff      <= idx_sel;
         range_ok_ff <= range_ok;
         match_ff    <= cell_match;
      end
      if (fire) begin
         rsp_value_ff <= rd_value;
         rsp_len_ff   <= count_in;
         rsp_stat_ff  <= stat_val;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = rsp_value_ff;
   assign rsp_bus.list_length = rsp_len_ff;
   assign rsp_bus.status      = rsp_stat_ff;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_list_engine. A short table of operations
// walks the edge cases: empty list, extreme positions and values, clamped
// insert, unused codes, duplicate removal. Random phases then grow the list
// to a full store, drain it back to empty and mix everything in between,
// with idle bursts on both channels and one long result-side stall. Each
// result is compared field by field to its typed row or an in-bench list model.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blec_pkg::*;

   localparam func_type FN_SPARE6        = 3'd6;
   localparam func_type FN_SPARE7        = 3'd7;
   localparam int       LONG_HOLD_CYCLES = 400;
   localparam int       DRAIN_CYCLES     = 20;
   localparam int       MAX_REPORTS      = 40;
   localparam int       TIMEOUT_NS       = 3_000_000;

   typedef struct packed {
      elem_type read_value;
      len_type  list_length;
      stat_type status;
   } list_result_type;

   typedef struct packed {
      func_type        op;
      pos_type         pos;
      elem_type        operand;
      logic            typed;
      list_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blec_req_if req_bus ();
   blec_rsp_if rsp_bus ();

   bounded_list_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // list model, advanced once per accepted item
   elem_type list_mem [DEPTH];
   int       model_len = 0;

   list_result_type pending_results [$];
   logic            row_typed;
   list_result_type row_want;

   bit idle_on          = 1'b1;
   bit hold_rsp_request = 1'b0;

   int ops_sent        = 0;
   int ops_accepted    = 0;
   int results_checked = 0;
   int fail_count      = 0;
   int peak_length     = 0;
   int full_refusals   = 0;
   int index_errors    = 0;
   int missing_values  = 0;

   // empty list, extremes, clamped insert, unused codes, duplicate removal
   directed_row_type directed_plan [25] = '{
      '{FN_GET,    16'sh0000, 64'h0,                  1'b1, '{64'h0, 9'd0, ST_RANGE}},
      '{FN_SET,    -16'sd1,   64'h1,                  1'b1, '{64'h0, 9'd0, ST_RANGE}},
      '{FN_POP,    -16'sd1,   64'h0,                  1'b1, '{64'h0, 9'd0, ST_RANGE}},
      '{FN_REMOVE, 16'sh0000, 64'h0,                  1'b1, '{64'h0, 9'd0, ST_MISSING}},
      '{FN_INSERT, 16'sd5,    64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{64'h0, 9'd1, ST_OK}},
      '{FN_APPEND, 16'sh0000, 64'h8000_0000_0000_0000, 1'b1, '{64'h0, 9'd2, ST_OK}},
      '{FN_GET,    16'sh8000, 64'h0,                  1'b1, '{64'h0, 9'd2, ST_RANGE}},
      '{FN_GET,    16'sh7FFF, 64'h0,                  1'b1, '{64'h0, 9'd2, ST_RANGE}},
      '{FN_GET,    -16'sd1,   64'h0,                  1'b1,
        '{64'h8000_0000_0000_0000, 9'd2, ST_OK}},
      '{FN_GET,    -16'sd2,   64'h0,                  1'b1,
        '{64'h7FFF_FFFF_FFFF_FFFF, 9'd2, ST_OK}},
      '{FN_GET,    -16'sd3,   64'h0,                  1'b1, '{64'h0, 9'd2, ST_RANGE}},
      '{FN_INSERT, 16'sh8000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{FN_INSERT, 16'sd1,    64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
      '{FN_INSERT, -16'sd1,   64'h0123_4567_89AB_CDEF, 1'b0, '0},
      '{FN_SET,    -16'sd5,   64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0},
      '{FN_SET,    16'sd5,    64'h1,                  1'b1, '{64'h0, 9'd5, ST_RANGE}},
      '{FN_SPARE6, -16'sd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'h0, 9'd5, ST_OK}},
      '{FN_SPARE7, 16'sh7FFF, 64'h0,                  1'b1, '{64'h0, 9'd5, ST_OK}},
      '{FN_REMOVE, 16'sh0000, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
      '{FN_REMOVE, 16'sh0000, 64'h0,                  1'b1, '{64'h0, 9'd4, ST_MISSING}},
      '{FN_APPEND, 16'sh0000, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
      '{FN_REMOVE, 16'sh0000, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
      '{FN_POP,    16'sh0000, 64'h0,                  1'b0, '0},
      '{FN_POP,    -16'sd1,   64'h0,                  1'b0, '0},
      '{FN_POP,    16'sh7FFF, 64'h0,                  1'b1, '{64'h0, 9'd2, ST_RANGE}}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d items sent, %0d results still due", ops_sent,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic list_result_type apply_list_op(func_type op, pos_type pos,
                                                     elem_type operand);
      list_result_type res;
      int  k;
      int  i;
      int  j;
      bit  found;
      res        = '0;
      res.status = ST_OK;
      k          = (pos < 0) ? model_len + int'(pos) : int'(pos);
      case (op)
         FN_GET: begin
            if (k >= 0 && k < model_len) res.read_value = list_mem[k];
            else res.status = ST_RANGE;
         end
         FN_SET: begin
            if (k >= 0 && k < model_len) list_mem[k] = operand;
            else res.status = ST_RANGE;
         end
         FN_APPEND: begin
            if (model_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               list_mem[model_len] = operand;
               model_len++;
            end
         end
         FN_POP: begin
            if (k >= 0 && k < model_len) begin
               res.read_value = list_mem[k];
               for (i = k; i < model_len - 1; i++) list_mem[i] = list_mem[i + 1];
               model_len--;
            end else begin
               res.status = ST_RANGE;
            end
         end
         FN_INSERT: begin
            if (model_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (k < 0) k = 0;
               if (k > model_len) k = model_len;
               for (i = model_len; i > k; i--) list_mem[i] = list_mem[i - 1];
               list_mem[k] = operand;
               model_len++;
            end
         end
         FN_REMOVE: begin
            res.status = ST_MISSING;
            found      = 1'b0;
            for (i = 0; i < model_len && !found; i++) begin
               if (list_mem[i] == operand) begin
                  found = 1'b1;
                  for (j = i; j < model_len - 1; j++) list_mem[j] = list_mem[j + 1];
                  model_len--;
                  res.status = ST_OK;
               end
            end
         end
         default: ;
      endcase
      res.list_length = len_type'(model_len);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] due);
      if (fail_count < MAX_REPORTS)
         $display("%0t ns: result %0d %s: got %h, expected %h", $time, results_checked,
                  what, seen, due);
      fail_count++;
   endtask

   // results are checked before the item accepted at the same edge is modeled
   always @(posedge clock) begin
      list_result_type seen;
      list_result_type due;
      list_result_type model;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{rsp_bus.read_value, rsp_bus.list_length, rsp_bus.status};
            results_checked++;
            if (pending_results.size() == 0) begin
               report_mismatch("arrived with nothing due", seen.read_value, 64'h0);
            end else begin
               due = pending_results.pop_front();
               if (seen.read_value !== due.read_value)
                  report_mismatch("read_value", seen.read_value, due.read_value);
               if (seen.list_length !== due.list_length)
                  report_mismatch("list_length", 64'(seen.list_length),
                                  64'(due.list_length));
               if (seen.status !== due.status)
                  report_mismatch("status", 64'(seen.status), 64'(due.status));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            model = apply_list_op(req_bus.func, req_bus.position, req_bus.operand_value);
            pending_results.push_back(row_typed ? row_want : model);
            ops_accepted++;
            if (model_len > peak_length) peak_length = model_len;
            case (model.status)
               ST_FULL:    full_refusals++;
               ST_RANGE:   index_errors++;
               ST_MISSING: missing_values++;
               default: ;
            endcase
         end
      end
   end

   // result side: ready runs and idle bursts, plus one long hold on request
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            n = LONG_HOLD_CYCLES;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            n = $urandom_range(1, 10);
         end else begin
            rsp_bus.ready <= 1'b1;
            n = idle_on ? $urandom_range(1, 30) : 1;
         end
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_op(func_type op, pos_type pos, elem_type operand, logic typed,
                          list_result_type want);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= op;
      req_bus.position      <= pos;
      req_bus.operand_value <= operand;
      row_typed             <= typed;
      row_want              <= want;
      ops_sent++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random(int grow_pct, int shrink_pct);
      func_type op;
      pos_type  pos;
      elem_type operand;
      int       pick;
      int       len_now;
      len_now = model_len;
      pick    = $urandom_range(0, 99);
      if (pick < grow_pct) op = $urandom_range(0, 1) ? FN_APPEND : FN_INSERT;
      else if (pick < grow_pct + shrink_pct) op = $urandom_range(0, 1) ? FN_POP : FN_REMOVE;
      else if (pick >= 98) op = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
      else op = $urandom_range(0, 1) ? FN_GET : FN_SET;

      case ($urandom_range(0, 9))
         0: pos = pos_type'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: pos = 16'sh8000;
               1: pos = 16'sh7FFF;
               2: pos = '0;
               default: pos = -16'sd1;
            endcase
         end
         // one step past either end
         2: pos = $urandom_range(0, 1) ? pos_type'(len_now) : pos_type'(-len_now - 1);
         default: begin
            if (len_now == 0) pos = '0;
            else pos = pos_type'(int'($urandom_range(0, 2 * len_now - 1)) - len_now);
         end
      endcase

      if (op == FN_REMOVE && len_now > 0 && $urandom_range(0, 9) < 7) begin
         operand = list_mem[$urandom_range(0, len_now - 1)];
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 3))
                  0: operand = 64'h8000_0000_0000_0000;
                  1: operand = 64'h7FFF_FFFF_FFFF_FFFF;
                  2: operand = '0;
                  default: operand = '1;
               endcase
            end
            // narrow set so duplicates show up
            1, 2: operand = elem_type'($urandom_range(0, 7));
            default: operand = {$urandom, $urandom};
         endcase
      end
      send_op(op, pos, operand, 1'b0, '0);
   endtask

   initial begin
      int extra;
      int tries;
      req_bus.valid         <= 1'b0;
      req_bus.func          <= FN_GET;
      req_bus.position      <= '0;
      req_bus.operand_value <= '0;
      row_typed             <= 1'b0;
      row_want              <= '0;
      do @(posedge clock); while (reset);

      foreach (directed_plan[r])
         send_op(directed_plan[r].op, directed_plan[r].pos, directed_plan[r].operand,
                 directed_plan[r].typed, directed_plan[r].want);

      repeat (250) send_random(40, 30);

      // grow to a full store and keep pushing; the result side holds off early on
      hold_rsp_request = 1'b1;
      extra = 0;
      tries = 0;
      while (extra < 60 && tries < 800) begin
         send_random(88, 5);
         if (model_len == DEPTH) extra++;
         tries++;
      end

      repeat (400) send_random(8, 80);
      repeat (250) send_random(35, 35);

      idle_on = 1'b0;
      repeat (200) send_random(35, 35);
      req_bus.valid <= 1'b0;

      while (ops_accepted != ops_sent || pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d list operations and %0d results; longest list %0d of %0d.",
               ops_accepted, results_checked, peak_length, DEPTH);
      $display("Refused: %0d on full store, %0d bad index or empty, %0d value not found.",
               full_refusals, index_errors, missing_values);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
